FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 convolution block.
// Holds only macro definitions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent on the same edge.
`define C3ZP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3zp assertion failed");

// Check that the antecedent implies the consequent on the next edge.
`define C3ZP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3zp assertion failed");

`endif

FILE: rtl/c3zp_pkg.sv
// Shared constants, types and helpers of the 3x3 convolution block.
// No dependencies.
package c3zp_pkg;

  // Line store depth and kernel weight width
  localparam int MAX_WIDTH = 1024;
  localparam int COEF_BITS = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = COL_W + 1;
  localparam int ROW_W   = 13;
  localparam int POS_W   = ROW_W + 2;
  localparam int PIX_W   = 24;
  localparam int COEF_W  = 24;
  localparam int DIV_W   = 12;
  localparam int HGT_W   = 12;
  localparam int OUT_W   = 20;
  localparam int PROD_W  = 9 + COEF_BITS;
  localparam int CFG_A_W = 3;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_DIVISOR  = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_HEIGHT   = 3'd5;

  // Input kind
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_PAD   = 1'b1;

  typedef logic signed [OUT_W-1:0] sum_t;

  // Pick weight k (0 = left) out of a packed kernel row
  function automatic logic signed [COEF_BITS-1:0] weight_of(
    input logic [COEF_W-1:0] row,
    input logic [1:0]        k
  );
    logic [3*COEF_BITS-1:0] ext;
    ext = (3*COEF_BITS)'(row);
    return ext[k*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

FILE: rtl/c3zp_div.sv
// Restoring divider for one colour channel: signed dividend, positive divisor,
// quotient truncated toward zero, one bit a cycle. Uses c3zp_pkg.
module c3zp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  c3zp_pkg::sum_t                dividend,
  input  logic [c3zp_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output c3zp_pkg::sum_t                quotient
);
  import c3zp_pkg::*;

  localparam int CNT_W = $clog2(OUT_W);

  logic [OUT_W-1:0] mag;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   shifted;
  logic             qbit;

  // One restoring step
  always_comb begin
    shifted = {rem, mag[OUT_W-1]};
    qbit    = (shifted >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: mag turns into the quotient bit by bit
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[OUT_W-1];
      mag <= dividend[OUT_W-1] ? OUT_W'(-dividend) : OUT_W'(dividend);
      rem <= '0;
      dvs <= (divisor == '0) ? DIV_W'(1) : divisor;
    end else if (busy) begin
      rem <= qbit ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
      mag <= {mag[OUT_W-2:0], qbit};
    end
  end

  assign quotient = neg ? sum_t'(-mag) : sum_t'(mag);

endmodule

FILE: rtl/conv3x3_zero_pad_rgb.sv
// Top level of the streaming 3x3 RGB convolution with zero padding.
// Uses c3zp_pkg, c3zp_div and assert_macros.svh.
//
// channel   dir  handshake          payload
// cfg       in   cfg_we             cfg_addr, cfg_data
// s (pixel) in   s_tvalid/s_tready  s_tdata {blue,green,red}, s_tuser req_type
// m (result)out  m_tvalid/m_tready  m_tdata {pad,blue,green,red}, m_tlast
//
// One word at a time: a word that yields no result is accepted and then
// read from the line store; one with a result then walks the nine taps
// through one multiplier per channel, goes through the divider (load,
// 20 steps, done) and finally loads the output register.
// The line stores need no clearing; reset clears state, counters, window, configuration and output valid.
// A stalled result is held in the output register while the next word
// is taken; a further result waits until that register empties.
module conv3x3_zero_pad_rgb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [c3zp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [c3zp_pkg::COEF_W-1:0]    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // in_red, in_green, in_blue
  input  logic                           s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,   // out_red, out_green, out_blue, zeros
  output logic                           m_tlast    // last_pixel
);
  import c3zp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers
  logic [COEF_W-1:0]  coef_top, coef_mid, coef_bot;
  logic [DIV_W-1:0]   divisor;
  logic [WIDTH_W-1:0] image_width;
  logic [HGT_W-1:0]   image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top     <= '0;
      coef_mid     <= COEF_W'(32'h10000);
      coef_bot     <= '0;
      divisor      <= DIV_W'(1);
      image_width  <= WIDTH_W'(MAX_WIDTH);
      image_height <= HGT_W'(768);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEF_TOP: coef_top     <= cfg_data;
        REG_COEF_MID: coef_mid     <= cfg_data;
        REG_COEF_BOT: coef_bot     <= cfg_data;
        REG_DIVISOR:  divisor      <= cfg_data[DIV_W-1:0];
        REG_WIDTH:    image_width  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:   image_height <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [WIDTH_W-1:0] wid;
  logic [HGT_W-1:0]   hgt;
  always_comb begin
    if (image_width == '0)
      wid = WIDTH_W'(1);
    else if (image_width > WIDTH_W'(MAX_WIDTH))
      wid = WIDTH_W'(MAX_WIDTH);
    else
      wid = image_width;
    hgt = (image_height == '0) ? HGT_W'(1) : image_height;
  end

  logic [2:0]        state;
  logic              accept;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [PIX_W-1:0]  pix_in;
  logic [PIX_W-1:0]  up_rd, lo_rd;
  logic [PIX_W-1:0]  line_upper [MAX_WIDTH];
  logic [PIX_W-1:0]  line_lower [MAX_WIDTH];
  logic [PIX_W-1:0]  window [9];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Line stores: read on accept, write back in the following cycle (ST_READ). The next
  // read comes no earlier than the cycle after the write, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd <= line_upper[column_count];
      lo_rd <= line_lower[column_count];
    end
    if (state == ST_READ) begin
      line_upper[column_count] <= lo_rd;
      line_lower[column_count] <= pix_in;
    end
  end

  // Capture the incoming word; padding enters as black
  always_ff @(posedge clk) begin
    if (accept)
      pix_in <= (s_tuser == REQ_PAD) ? '0 : s_tdata;
  end

  // Output position of the word in flight
  logic signed [POS_W-1:0] orow, orow_next;
  logic [COL_W-1:0]        ocol, ocol_next;
  logic [WIDTH_W-1:0]      col_inc;
  logic                    last_next;
  always_comb begin
    if (column_count == '0) begin
      ocol_next = COL_W'(wid - 1'b1);
      orow_next = $signed({2'b00, row_count}) - POS_W'(2);
    end else begin
      ocol_next = column_count - 1'b1;
      orow_next = $signed({2'b00, row_count}) - POS_W'(1);
    end
    col_inc   = WIDTH_W'(column_count) + 1'b1;
    last_next = (orow_next >= $signed(POS_W'(hgt) - POS_W'(1)))
             && (WIDTH_W'(ocol_next) == wid - 1'b1)
             && !orow_next[POS_W-1];
  end

  // Tap walk
  logic [1:0] tap_r, tap_c;
  logic [3:0] tap_cnt;
  logic       last_q;
  logic       div_start;
  logic       div_done;
  sum_t       quot_r, quot_g, quot_b;
  sum_t       sum_r, sum_g, sum_b;
  logic signed [PROD_W-1:0] prod_r, prod_g, prod_b;

  // Sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      tap_cnt      <= '0;
      tap_r        <= '0;
      tap_c        <= '0;
      div_start    <= 1'b0;
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_READ;
        end
        ST_READ: begin
          // shift the window and advance the position
          for (int r = 0; r < 3; r++) begin
            window[r*3]   <= window[r*3+1];
            window[r*3+1] <= window[r*3+2];
          end
          window[2] <= up_rd;
          window[5] <= lo_rd;
          window[8] <= pix_in;
          orow   <= orow_next;
          ocol   <= ocol_next;
          last_q <= last_next;
          if (!orow_next[POS_W-1] && last_next) begin
            column_count <= '0;
            row_count    <= '0;
          end else if (col_inc >= wid) begin
            column_count <= '0;
            row_count    <= row_count + 1'b1;
          end else begin
            column_count <= col_inc[COL_W-1:0];
          end
          tap_cnt <= '0;
          tap_r   <= '0;
          tap_c   <= '0;
          state   <= orow_next[POS_W-1] ? ST_IDLE : ST_MAC;
        end
        ST_MAC: begin
          tap_cnt <= tap_cnt + 1'b1;
          if (tap_c == 2'd2) begin
            tap_c <= '0;
            tap_r <= tap_r + 1'b1;
          end else begin
            tap_c <= tap_c + 1'b1;
          end
          if (tap_cnt == 4'd9) begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Tap in range of the frame (the centre always counts)
  logic signed [POS_W:0]   tr;
  logic signed [WIDTH_W+1:0] tc;
  logic                    tap_ok;
  logic [PIX_W-1:0]        tap_pix;
  logic [COEF_W-1:0]       tap_row;
  logic signed [COEF_BITS-1:0] wgt;
  always_comb begin
    tr = (POS_W+1)'(orow) + (POS_W+1)'(tap_r) - (POS_W+1)'(1);
    tc = $signed((WIDTH_W+2)'(ocol)) + (WIDTH_W+2)'(tap_c) - (WIDTH_W+2)'(1);
    tap_ok = ((tap_r == 2'd1) && (tap_c == 2'd1))
          || (!tr[POS_W] && (tr < $signed((POS_W+1)'(hgt)))
              && !tc[WIDTH_W+1] && (tc < $signed((WIDTH_W+2)'(wid))));
    tap_pix = window[4'(tap_r) * 4'd3 + 4'(tap_c)];
    case (tap_r)
      2'd0:    tap_row = coef_top;
      2'd1:    tap_row = coef_mid;
      default: tap_row = coef_bot;
    endcase
    wgt = weight_of(tap_row, tap_c);
  end

  // Multiply, register, then accumulate
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (state == ST_MAC) begin
      if (tap_cnt != 4'd9) begin
        prod_r <= tap_ok ? $signed({1'b0, tap_pix[7:0]})   * wgt : $signed(PROD_W'(0));
        prod_g <= tap_ok ? $signed({1'b0, tap_pix[15:8]})  * wgt : $signed(PROD_W'(0));
        prod_b <= tap_ok ? $signed({1'b0, tap_pix[23:16]}) * wgt : $signed(PROD_W'(0));
      end
      if (tap_cnt != 4'd0) begin
        sum_r <= sum_r + OUT_W'(prod_r);
        sum_g <= sum_g + OUT_W'(prod_g);
        sum_b <= sum_b + OUT_W'(prod_b);
      end
    end
  end

  c3zp_div u_div_r (.clk(clk), .rst(rst), .start(div_start), .dividend(sum_r),
                    .divisor(divisor), .done(div_done), .quotient(quot_r));
  c3zp_div u_div_g (.clk(clk), .rst(rst), .start(div_start), .dividend(sum_g),
                    .divisor(divisor), .done(), .quotient(quot_g));
  c3zp_div u_div_b (.clk(clk), .rst(rst), .start(div_start), .dividend(sum_b),
                    .divisor(divisor), .done(), .quotient(quot_b));

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {4'b0, quot_b, quot_g, quot_r};
      m_tlast  <= last_q;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `include "assert_macros.svh"

  `C3ZP_ASSERT_NEXT(a_accept_reads, clk, rst, accept, state == ST_READ)
  `C3ZP_ASSERT_SAME(a_done_in_div, clk, rst, div_done, state == ST_DIV)
  `C3ZP_ASSERT_NEXT(a_out_loads, clk, rst, (state == ST_OUT) && (!m_tvalid || m_tready), m_tvalid)

endmodule

FILE: tb/conv3x3_checker.sv
// Result checker for conv3x3_zero_pad_rgb: watches the config, pixel and result channels.
// Keeps its own copy of the convolution state and compares each result word.
// Depends on c3zp_pkg.
`timescale 1ns / 100ps

module conv3x3_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [c3zp_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [c3zp_pkg::COEF_W-1:0]  cfg_data,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [23:0]                  s_tdata,   // in_red, in_green, in_blue
  input  logic                         s_tuser,   // req_type
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [63:0]                  m_tdata,   // out_red, out_green, out_blue, zeros
  input  logic                         m_tlast,   // last_pixel
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import c3zp_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             last;
  } conv_pixel_t;

  conv_pixel_t conv_expect_q[$];

  logic [COEF_W-1:0] k_top, k_mid, k_bot;
  logic [DIV_W-1:0]  div_r;
  logic [10:0]       wid_r;
  logic [HGT_W-1:0]  hgt_r;
  logic [PIX_W-1:0]  line_up[MAX_WIDTH];
  logic [PIX_W-1:0]  line_lo[MAX_WIDTH];
  logic [PIX_W-1:0]  win[9];
  int unsigned       col_cnt, row_cnt;

  assign pending = conv_expect_q.size();

  // Advance the window by one word and queue the result it yields, if any
  task automatic predict_pixel(input logic kind, input logic [23:0] data);
    int w, h, dv, c, orow, ocol, r, cc, sum, pix;
    logic [PIX_W-1:0] x, up, lo;
    logic [COEF_W-1:0] krow;
    logic signed [COEF_BITS-1:0] wt;
    logic [OUT_W-1:0] q[3];
    conv_pixel_t e;
    w = (wid_r == 0) ? 1 : (wid_r > MAX_WIDTH ? MAX_WIDTH : int'(wid_r));
    h = (hgt_r == 0) ? 1 : int'(hgt_r);
    dv = (div_r == 0) ? 1 : int'(div_r);
    x = (kind == REQ_PAD) ? '0 : data;
    c = col_cnt % MAX_WIDTH;
    up = line_up[c];
    lo = line_lo[c];
    line_up[c] = lo;
    line_lo[c] = x;
    for (int dr = 0; dr < 3; dr++) begin
      win[dr*3]   = win[dr*3+1];
      win[dr*3+1] = win[dr*3+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = x;
    if (col_cnt == 0) begin
      ocol = w - 1;
      orow = int'(row_cnt) - 2;
    end else begin
      ocol = int'(col_cnt) - 1;
      orow = int'(row_cnt) - 1;
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 32'h1FFF;
    end
    if (orow < 0) return;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int dr = 0; dr < 3; dr++) begin
        krow = (dr == 0) ? k_top : (dr == 1) ? k_mid : k_bot;
        r = orow + dr - 1;
        for (int dc = 0; dc < 3; dc++) begin
          cc = ocol + dc - 1;
          // outside neighbours count as zero, the centre always counts
          if ((dr != 1 || dc != 1) && (r < 0 || r >= h || cc < 0 || cc >= w)) continue;
          wt = krow[dc*COEF_BITS +: COEF_BITS];
          pix = int'(win[dr*3+dc][8*ch +: 8]);
          sum += pix * int'(wt);
        end
      end
      q[ch] = OUT_W'(sum / dv);
    end
    e.red = q[0];
    e.green = q[1];
    e.blue = q[2];
    e.last = (orow >= h - 1 && ocol == w - 1);
    if (e.last) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    conv_expect_q.push_back(e);
  endtask

  // Compare one result word with the oldest expectation
  task automatic check_result();
    conv_pixel_t e;
    if (conv_expect_q.size() == 0) begin
      $display("%0t: unexpected result word %h last %b", $time, m_tdata, m_tlast);
      errors++;
      return;
    end
    e = conv_expect_q.pop_front();
    checked++;
    if (m_tdata[19:0] !== e.red) begin
      $display("%0t: red expected %h actual %h", $time, e.red, m_tdata[19:0]);
      errors++;
    end
    if (m_tdata[39:20] !== e.green) begin
      $display("%0t: green expected %h actual %h", $time, e.green, m_tdata[39:20]);
      errors++;
    end
    if (m_tdata[59:40] !== e.blue) begin
      $display("%0t: blue expected %h actual %h", $time, e.blue, m_tdata[59:40]);
      errors++;
    end
    if (m_tlast !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    checked = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_up[i] = '0;
      line_lo[i] = '0;
    end
  end

  // Track registers, words in and results out
  always @(posedge clk) begin
    if (rst) begin
      k_top = '0;
      k_mid = 24'h010000;
      k_bot = '0;
      div_r = 1;
      wid_r = 1024;
      hgt_r = 768;
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      conv_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_COEF_TOP: k_top = cfg_data;
          REG_COEF_MID: k_mid = cfg_data;
          REG_COEF_BOT: k_bot = cfg_data;
          REG_DIVISOR:  div_r = cfg_data[DIV_W-1:0];
          REG_WIDTH:    wid_r = cfg_data[10:0];
          REG_HEIGHT:   hgt_r = cfg_data[HGT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_pixel(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
  end

endmodule

FILE: tb/tb_conv3x3_zero_pad_rgb.sv
// Top testbench of conv3x3_zero_pad_rgb: clock, reset, frame stimulus and verdict.
// Depends on c3zp_pkg, the block itself and conv3x3_checker.
`timescale 1ns / 100ps

module tb_conv3x3_zero_pad_rgb;
  import c3zp_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [COEF_W-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata = '0;   // in_red, in_green, in_blue
  logic                s_tuser = 1'b0; // req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [63:0]         m_tdata;        // out_red, out_green, out_blue, zeros
  logic                m_tlast;        // last_pixel

  int errors, pending, checked;
  int words_sent = 0;
  int frames = 0;
  int idle_s = 0;
  int idle_m = 0;
  int m_hold = 0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  conv3x3_zero_pad_rgb DUT (.*);

  conv3x3_checker u_checker (.*);

  // Receiver: while idle_m is set, stall for a random spell after each result word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_hold > 0) begin
      m_hold--;
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      m_hold = idle_m ? $urandom_range(0, 13) : 0;
      m_tready <= (m_hold == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_pixel();
    return {pick_chan(), pick_chan(), pick_chan()};
  endfunction

  function automatic logic [23:0] pick_kernel();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h808080;
      3: return 24'h7F7F7F;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic kind, input logic [23:0] data);
    int gap;
    gap = idle_s ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Hold until every result is out and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(input logic [23:0] kt, input logic [23:0] km,
                           input logic [23:0] kb, input int dv, input int w, input int h);
    logic [23:0] vals[6];
    vals = '{kt, km, kb, 24'(dv), 24'(w), 24'(h)};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= CFG_A_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One frame followed by the drain words; noise drops black pads into the image
  task automatic send_frame(input int w, input int h, input int noise);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise) send_word(REQ_PAD, pick_pixel());
      else send_word(REQ_PIXEL, pick_pixel());
    end
    // a pixel after the frame acts as a pad too
    for (int i = 0; i <= w; i++)
      send_word(($urandom_range(0, 7) == 0) ? REQ_PIXEL : REQ_PAD, pick_pixel());
    frames++;
  endtask

  initial begin
    int w, h, dv;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: strongest positive and negative kernels, both divisor extremes
    configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 1, 3, 3);
    for (int i = 0; i < 9; i++) send_word(REQ_PIXEL, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_word(REQ_PAD, 24'hFFFFFF);
    frames++;
    configure(24'h808080, 24'h808080, 24'h808080, 4095, 2, 2);
    send_word(REQ_PIXEL, 24'hFFFFFF);
    send_word(REQ_PIXEL, 24'h000000);
    send_word(REQ_PAD, 24'hFFFFFF);
    send_word(REQ_PIXEL, 24'hFF00FF);
    for (int i = 0; i < 3; i++) send_word(REQ_PAD, 24'h000000);
    frames++;
    configure(24'h000000, 24'h010000, 24'h000000, 1, 1, 1);
    send_word(REQ_PIXEL, 24'hA5C3FF);
    send_word(REQ_PAD, 24'h0);
    send_word(REQ_PAD, 24'h0);
    frames++;

    // Rows past the final one: tall frame cut short by lowering the height
    configure(pick_kernel(), pick_kernel(), pick_kernel(), 3, 2, 4095);
    for (int i = 0; i < 6; i++) send_word(REQ_PIXEL, pick_pixel());
    configure(pick_kernel(), pick_kernel(), pick_kernel(), 3, 2, 3);
    for (int i = 0; i < 3; i++) send_word(REQ_PAD, pick_pixel());
    frames++;

    // Random frames, mostly small
    idle_s = 1;
    idle_m = 1;
    while (words_sent < 700) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      case ($urandom_range(0, 3))
        0: dv = 1;
        1: dv = 4095;
        default: dv = $urandom_range(1, 300);
      endcase
      configure(pick_kernel(), pick_kernel(), pick_kernel(), dv, w, h);
      idle_s = $urandom_range(0, 3) != 0;
      idle_m = $urandom_range(0, 3) != 0;
      send_frame(w, h, $urandom_range(0, 1) ? 5 : 0);
    end

    // One wide line
    idle_s = 0;
    configure(pick_kernel(), pick_kernel(), pick_kernel(), $urandom_range(1, 64), 600, 1);
    send_frame(600, 1, 0);

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words in %0d frames, widths 1 to 600, divisors 1 to 4095.",
             words_sent, frames);
    $display("Checked %0d result words, %0d mismatches.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/c3zp_pkg.sv
rtl/c3zp_div.sv
rtl/conv3x3_zero_pad_rgb.sv
tb/conv3x3_checker.sv
tb/tb_conv3x3_zero_pad_rgb.sv
